// ----- hw/rtl/bpse_pkg.sv -----
// ----------------------------------------------------------------------------
// bpse_pkg
// Shared types and constants of the bmp pixel stream encoder.
// ----------------------------------------------------------------------------
package bpse_pkg;

    // field widths
    localparam int DIM_W  = 13;   // image width / height registers
    localparam int DIV_W  = 16;   // sample count register
    localparam int SUM_W  = 24;   // accumulated color sums
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 2;
    localparam int DATA_W = 16;
    localparam int IN_W   = 3 * SUM_W;
    localparam int IDX_W  = 6;    // byte index within one item's output
    localparam int ROWB_W = DIM_W + 2;      // padded bytes per row
    localparam int IMG_W  = ROWB_W + DIM_W; // padded image size in bytes

    // default limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // file format constants
    localparam logic [IDX_W-1:0]  HDR_BYTES  = 6'd54;
    localparam logic [IDX_W-1:0]  HDR_LAST   = 6'd53;
    localparam logic [BYTE_W-1:0] INFO_BYTES = 8'd40;
    localparam logic [BYTE_W-1:0] BITS_PP    = 8'd24;
    localparam logic [BYTE_W-1:0] CHAR_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CHAR_M     = 8'h4D;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [ADDR_W-1:0] REG_SAMPLE_COUNT = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_PREP,
        S_HDR,
        S_DIV,
        S_PIX
    } bpse_state_t;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic prep;
        logic emit;
    } bpse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic start_req;
        logic div_done;
        logic emit_last;
        logic out_free;
    } bpse_sts_t;

endpackage

// ----- hw/rtl/bpse_divider.sv -----
// ----------------------------------------------------------------------------
// bpse_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpse_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bpse_pkg::SUM_W-1:0] dividend,
    input  logic [bpse_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic [bpse_pkg::SUM_W-1:0] quotient
);
    import bpse_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W:0]   rem_sh;
    logic             fits;

    // one restoring step
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        fits     = rem_sh >= {1'b0, dsr_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = (divisor == '0) ? DIV_W'(1) : divisor;
            cnt_next  = CNT_W'(SUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DIV_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/bpse_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpse_ctrl
// Sequencer: header emission, division wait and pixel byte emission.
// ----------------------------------------------------------------------------
module bpse_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bpse_pkg::bpse_sts_t   sts,
    output bpse_pkg::bpse_cmd_t   cmd,
    output bpse_pkg::bpse_state_t state
);
    import bpse_pkg::*;

    bpse_state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (sts.in_valid) begin
                    state_next = sts.start_req ? S_HDR_PREP : S_DIV;
                end
            end
            S_HDR_PREP: state_next = S_HDR;
            S_HDR: begin
                if (sts.out_free && sts.emit_last) begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_PIX;
                end
            end
            S_PIX: begin
                if (sts.out_free && sts.emit_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.accept   = sts.in_valid;
            end
            S_HDR_PREP: cmd.prep = 1'b1;
            S_HDR:      cmd.emit = sts.out_free;
            S_PIX:      cmd.emit = sts.out_free;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- hw/rtl/bpse_datapath.sv -----
// ----------------------------------------------------------------------------
// bpse_datapath
// Config registers, color dividers, header bytes, position counters
// and the output word register.
// ----------------------------------------------------------------------------
module bpse_datapath #(
    parameter int MAX_WIDTH  = bpse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bpse_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [bpse_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [bpse_pkg::DATA_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    input  logic [bpse_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tuser,
    input  bpse_pkg::bpse_cmd_t         cmd,
    output bpse_pkg::bpse_sts_t         sts,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bpse_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import bpse_pkg::*;

    localparam logic [16:0] MAX_W_L = 17'(MAX_WIDTH);
    localparam logic [16:0] MAX_H_L = 17'(MAX_HEIGHT);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [DIV_W-1:0]  samples_reg;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              hdr_reg;
    logic [IMG_W-1:0]  img_reg;
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] odata_reg, odata_next;
    logic              olast_reg, olast_next;
    logic              odone_reg, odone_next;

    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [1:0]        w3_lo, pad;
    logic [ROWB_W-1:0] row_bytes;
    logic [31:0]       total_bytes;
    logic              row_end, frame_end, last_byte;
    logic [BYTE_W-1:0] hdr_byte, pix_byte;
    logic [SUM_W-1:0]  q_red, q_green, q_blue;
    logic              busy_red, busy_green, busy_blue;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= DIM_W'(1);
            height_reg  <= DIM_W'(1);
            samples_reg <= DIV_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg   <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_wdata[DIM_W-1:0];
                REG_SAMPLE_COUNT: samples_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective dimensions and row padding
    always_comb begin
        if (width_reg == '0) begin
            eff_w = DIM_W'(1);
        end else if ({4'd0, width_reg} > MAX_W_L) begin
            eff_w = MAX_W_L[DIM_W-1:0];
        end else begin
            eff_w = width_reg;
        end
        if (height_reg == '0) begin
            eff_h = DIM_W'(1);
        end else if ({4'd0, height_reg} > MAX_H_L) begin
            eff_h = MAX_H_L[DIM_W-1:0];
        end else begin
            eff_h = height_reg;
        end
        w3_lo     = 2'(eff_w[1:0] + {eff_w[0], 1'b0});
        pad       = 2'(2'd0 - w3_lo);
        row_bytes = ROWB_W'({2'b00, eff_w} + {1'b0, eff_w, 1'b0} + {{(ROWB_W-2){1'b0}}, pad});
        total_bytes = {{(32-IMG_W){1'b0}}, img_reg} + {26'd0, HDR_BYTES};
    end

    // three color dividers run side by side
    bpse_divider u_div_red (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.accept),
        .dividend (s_tdata[SUM_W-1:0]),
        .divisor  (samples_reg),
        .busy     (busy_red),
        .quotient (q_red)
    );

    bpse_divider u_div_green (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.accept),
        .dividend (s_tdata[2*SUM_W-1:SUM_W]),
        .divisor  (samples_reg),
        .busy     (busy_green),
        .quotient (q_green)
    );

    bpse_divider u_div_blue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.accept),
        .dividend (s_tdata[3*SUM_W-1:2*SUM_W]),
        .divisor  (samples_reg),
        .busy     (busy_blue),
        .quotient (q_blue)
    );

    // header byte select, little-endian words
    always_comb begin
        case (idx_reg)
            6'd0:    hdr_byte = CHAR_B;
            6'd1:    hdr_byte = CHAR_M;
            6'd2:    hdr_byte = total_bytes[7:0];
            6'd3:    hdr_byte = total_bytes[15:8];
            6'd4:    hdr_byte = total_bytes[23:16];
            6'd5:    hdr_byte = total_bytes[31:24];
            6'd10:   hdr_byte = {2'b00, HDR_BYTES};
            6'd14:   hdr_byte = INFO_BYTES;
            6'd18:   hdr_byte = eff_w[7:0];
            6'd19:   hdr_byte = {3'd0, eff_w[DIM_W-1:8]};
            6'd22:   hdr_byte = eff_h[7:0];
            6'd23:   hdr_byte = {3'd0, eff_h[DIM_W-1:8]};
            6'd26:   hdr_byte = 8'd1;
            6'd28:   hdr_byte = BITS_PP;
            6'd34:   hdr_byte = img_reg[7:0];
            6'd35:   hdr_byte = img_reg[15:8];
            6'd36:   hdr_byte = img_reg[23:16];
            6'd37:   hdr_byte = {{(32-IMG_W){1'b0}}, img_reg[IMG_W-1:24]};
            default: hdr_byte = '0;
        endcase
    end

    // pixel byte select: blue, green, red, then padding
    always_comb begin
        case (idx_reg)
            6'd0:    pix_byte = q_blue[BYTE_W-1:0];
            6'd1:    pix_byte = q_green[BYTE_W-1:0];
            6'd2:    pix_byte = q_red[BYTE_W-1:0];
            default: pix_byte = '0;
        endcase
    end

    // row and frame end, last byte of the current item
    always_comb begin
        row_end   = ({1'b0, col_reg} + 1'b1) >= {1'b0, eff_w};
        frame_end = row_end && (({1'b0, row_reg} + 1'b1) >= {1'b0, eff_h});
        if (hdr_reg) begin
            last_byte = idx_reg == HDR_LAST;
        end else if (row_end) begin
            last_byte = idx_reg == IDX_W'(3'd2 + {1'b0, pad});
        end else begin
            last_byte = idx_reg == IDX_W'(2);
        end
    end

    // byte index and position counters
    always_comb begin
        idx_next = idx_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.accept) begin
            idx_next = '0;
        end else if (cmd.emit) begin
            idx_next = idx_reg + 1'b1;
            if (last_byte) begin
                if (hdr_reg) begin
                    col_next = '0;
                    row_next = '0;
                end else if (row_end) begin
                    col_next = '0;
                    row_next = frame_end ? '0 : row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    // output word register
    always_comb begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        odone_next  = odone_reg;
        if (cmd.emit) begin
            ovalid_next = 1'b1;
            odata_next  = hdr_reg ? hdr_byte : pix_byte;
            olast_next  = last_byte;
            odone_next  = last_byte && !hdr_reg && frame_end;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            idx_reg    <= '0;
            hdr_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
            if (cmd.accept) begin
                hdr_reg <= !s_tuser;
            end
        end
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
        // padded image size, once per header
        if (cmd.prep) begin
            img_reg <= IMG_W'(row_bytes * eff_h);
        end
    end

    // status to the controller
    always_comb begin
        sts.in_valid  = s_tvalid;
        sts.start_req = !s_tuser;
        sts.div_done  = !(busy_red || busy_green || busy_blue);
        sts.emit_last = last_byte;
        sts.out_free  = !ovalid_reg || m_tready;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = odone_reg;

endmodule

// ----- hw/rtl/bmp_pixel_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_stream_encoder
// Streams a 24-bit BMP file: header on a start word, BGR bytes plus
// row padding for each pixel word.
// ----------------------------------------------------------------------------
// Start word: 54 header bytes after a prep state, one per cycle while the
// output is not stalled; no new word is taken until the last is loaded.
// Pixel word: the bit-serial dividers run first (one quotient bit a
// cycle), then 3 to 6 bytes at one a cycle unless the output stalls.
// Reset (aresetn low, synchronous) clears positions and output valid and
// sets width, height and sample count to 1.
module bmp_pixel_stream_encoder #(
    parameter int MAX_WIDTH  = bpse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bpse_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration writes
    input  logic                        cfg_we,
    input  logic [bpse_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [bpse_pkg::DATA_W-1:0] cfg_wdata,
    // input words
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bpse_pkg::IN_W-1:0]   s_tdata,   // red_sum, green_sum, blue_sum
    input  logic                        s_tuser,   // mode
    // output words
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bpse_pkg::BYTE_W-1:0] m_tdata,   // out_byte
    output logic                        m_tlast,   // run_last
    output logic                        m_tuser    // frame_done
);
    import bpse_pkg::*;

    bpse_cmd_t   cmd;
    bpse_sts_t   sts;
    bpse_state_t state;

    bpse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd),
        .state   (state)
    );

    bpse_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    assign s_tready = cmd.in_ready;

    // frame end only on the closing byte of a pixel
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_done without run_last");

    // no byte goes out while the dividers still run
    a_no_emit_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state == S_DIV |-> !cmd.emit)
        else $error("byte emitted during division");

    // closing byte of an item returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && sts.emit_last |=> state == S_IDLE && m_tvalid && m_tlast)
        else $error("sequencer did not finish after last byte");

endmodule
